### rtl/tilt_pkg.sv
// Package for the accelerometer tilt-angle pipeline.
// Holds the shared widths, reset values, register indexes and the CORDIC arctangent table.
// It depends on nothing else.
package tilt_pkg;

   localparam int DEFAULT_SAMPLE_BITS      = 12;
   localparam int DEFAULT_ITERATION_STAGES = 16;

   // Configuration port
   localparam int CSR_WIDTH       = 12;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_WIDTH-1:0] ZERO_G_RESET       = 12'd2048;
   localparam logic [CSR_WIDTH-1:0] COUNTS_PER_G_RESET = 12'd246;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ZERO_G       = 1'b0,
      CSR_COUNTS_PER_G = 1'b1
   } csr_index_type;

   // Result fields
   localparam int MAG_WIDTH   = 12;
   localparam logic [MAG_WIDTH-1:0] MAG_MAX = 12'd4095;
   localparam int ANGLE_WIDTH = 15;

   // Fixed-point scaling
   localparam int SCALE_SHIFT    = 8;
   localparam int RADICAND_SHIFT = 16;
   localparam int ANGLE_FRAC     = 12;
   localparam int ZACC_WIDTH     = 29;
   localparam int ATAN_ENTRIES   = 24;
   localparam logic signed [ZACC_WIDTH-1:0] ANGLE_90  = 29'sd36864000;
   localparam logic signed [ZACC_WIDTH-1:0] ANGLE_180 = 29'sd73728000;

   // atan(2^-i) in hundredths of a degree, scaled by 4096 and rounded
   function automatic logic signed [ZACC_WIDTH-1:0] atan_value(input logic [4:0] idx);
      logic signed [ZACC_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 29'sd18432000;
         5'd1:    val = 29'sd10881045;
         5'd2:    val = 29'sd5749245;
         5'd3:    val = 29'sd2918407;
         5'd4:    val = 29'sd1464867;
         5'd5:    val = 29'sd733147;
         5'd6:    val = 29'sd366663;
         5'd7:    val = 29'sd183343;
         5'd8:    val = 29'sd91673;
         5'd9:    val = 29'sd45837;
         5'd10:   val = 29'sd22918;
         5'd11:   val = 29'sd11459;
         5'd12:   val = 29'sd5730;
         5'd13:   val = 29'sd2865;
         5'd14:   val = 29'sd1432;
         5'd15:   val = 29'sd716;
         5'd16:   val = 29'sd358;
         5'd17:   val = 29'sd179;
         5'd18:   val = 29'sd90;
         5'd19:   val = 29'sd45;
         5'd20:   val = 29'sd22;
         5'd21:   val = 29'sd11;
         5'd22:   val = 29'sd6;
         5'd23:   val = 29'sd3;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/tilt_delay.sv
// Delay line that keeps side data in step with the pipeline.
// Uses nothing from the package; advances only when the pipeline advances.
module tilt_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   generate
      if (DEPTH == 0) begin : g_none
         assign dout = din;
      end else begin : g_line
         logic [WIDTH-1:0] tap_ff [DEPTH];

         // Shift one place per advancing cycle.
         always_ff @(posedge clock) begin
            if (adv) begin
               tap_ff[0] <= din;
               for (int k = 1; k < DEPTH; k++) begin
                  tap_ff[k] <= tap_ff[k-1];
               end
            end
         end

         assign dout = tap_ff[DEPTH-1];
      end
   endgenerate

endmodule

### rtl/tilt_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on tilt_pkg only through the common import.
module tilt_sqrt import tilt_pkg::*; #(
   parameter int ROOT_BITS = 21
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [2*ROOT_BITS-1:0] radicand,
   output logic [ROOT_BITS-1:0]   root
);

   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 3;

   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   generate
      for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
         logic [RAD_BITS-1:0]  rad_src;
         logic [REM_BITS-1:0]  rem_src;
         logic [ROOT_BITS-1:0] root_src;
         logic [REM_BITS-1:0]  rem_try;
         logic [REM_BITS-1:0]  trial;
         logic [REM_BITS-1:0]  rem_in;
         logic [ROOT_BITS-1:0] root_in;

         if (k == 0) begin : g_first
            assign rad_src  = radicand;
            assign rem_src  = '0;
            assign root_src = '0;
         end else begin : g_next
            assign rad_src  = rad_ff[k-1];
            assign rem_src  = rem_ff[k-1];
            assign root_src = root_ff[k-1];
         end

         // Bring down the next two radicand bits and try the next root bit.
         always_comb begin
            rem_try = {rem_src[REM_BITS-3:0], rad_src[RAD_BITS-1:RAD_BITS-2]};
            trial   = {1'b0, root_src, 2'b01};
            if (rem_try >= trial) begin
               rem_in  = rem_try - trial;
               root_in = {root_src[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_try;
               root_in = {root_src[ROOT_BITS-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rad_ff[k]  <= {rad_src[RAD_BITS-3:0], 2'b00};
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
            end
         end
      end
   endgenerate

   assign root = root_ff[ROOT_BITS-1];

endmodule

### rtl/tilt_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Divides by a configuration value of CSR_WIDTH bits from tilt_pkg.
module tilt_div import tilt_pkg::*; #(
   parameter int NUM_BITS = 22
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [NUM_BITS-1:0]  numer,
   input  logic [CSR_WIDTH-1:0] denom,
   output logic [NUM_BITS-1:0]  quot
);

   logic [NUM_BITS-1:0]  num_ff [NUM_BITS];
   logic [CSR_WIDTH-1:0] rem_ff [NUM_BITS];
   logic [NUM_BITS-1:0]  quo_ff [NUM_BITS];

   generate
      for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
         logic [NUM_BITS-1:0]  num_src;
         logic [CSR_WIDTH-1:0] rem_src;
         logic [NUM_BITS-1:0]  quo_src;
         logic [CSR_WIDTH:0]   rem_try;
         logic [CSR_WIDTH-1:0] rem_in;
         logic                 bit_in;

         if (k == 0) begin : g_first
            assign num_src = numer;
            assign rem_src = '0;
            assign quo_src = '0;
         end else begin : g_next
            assign num_src = num_ff[k-1];
            assign rem_src = rem_ff[k-1];
            assign quo_src = quo_ff[k-1];
         end

         // Shift in the next numerator bit and subtract where it fits.
         always_comb begin
            rem_try = {rem_src, num_src[NUM_BITS-1]};
            if (rem_try >= {1'b0, denom}) begin
               rem_in = CSR_WIDTH'(rem_try - {1'b0, denom});
               bit_in = 1'b1;
            end else begin
               rem_in = rem_try[CSR_WIDTH-1:0];
               bit_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               num_ff[k] <= {num_src[NUM_BITS-2:0], 1'b0};
               rem_ff[k] <= rem_in;
               quo_ff[k] <= {quo_src[NUM_BITS-2:0], bit_in};
            end
         end
      end
   endgenerate

   assign quot = quo_ff[NUM_BITS-1];

endmodule

### rtl/tilt_cordic.sv
// Vectoring CORDIC that turns an axis count and its perpendicular part into an angle.
// Uses the arctangent table and angle constants of tilt_pkg.
module tilt_cordic import tilt_pkg::*; #(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
   parameter int ROOT_BITS   = DEFAULT_SAMPLE_BITS + 9,
   parameter int NUM_STAGES  = DEFAULT_ITERATION_STAGES
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic signed [SAMPLE_BITS:0]   axis,
   input  logic        [ROOT_BITS-1:0]   perp,
   output logic        [ANGLE_WIDTH-1:0] angle
);

   localparam int XW = ROOT_BITS + 3;

   logic signed [XW-1:0]         x_ff [NUM_STAGES+1];
   logic signed [XW-1:0]         y_ff [NUM_STAGES+1];
   logic signed [ZACC_WIDTH-1:0] z_ff [NUM_STAGES+1];
   logic        [ANGLE_WIDTH-1:0] angle_ff;

   logic signed [XW-1:0] axis_scaled;
   logic signed [XW-1:0] perp_ext;

   // Pre-rotation: a negative axis is turned by 90 degrees first.
   assign axis_scaled = XW'(axis) <<< SCALE_SHIFT;
   assign perp_ext    = signed'(XW'(perp));

   always_ff @(posedge clock) begin
      if (adv) begin
         if (axis < 0) begin
            x_ff[0] <= perp_ext;
            y_ff[0] <= -axis_scaled;
            z_ff[0] <= ANGLE_90;
         end else begin
            x_ff[0] <= axis_scaled;
            y_ff[0] <= perp_ext;
            z_ff[0] <= '0;
         end
      end
   end

   // One micro-rotation per stage, driving y towards zero.
   generate
      for (genvar i = 0; i < NUM_STAGES; i++) begin : g_iter
         logic signed [XW-1:0] xs;
         logic signed [XW-1:0] ys;

         assign xs = x_ff[i] >>> i;
         assign ys = y_ff[i] >>> i;

         always_ff @(posedge clock) begin
            if (adv) begin
               if (y_ff[i] > 0) begin
                  x_ff[i+1] <= x_ff[i] + ys;
                  y_ff[i+1] <= y_ff[i] - xs;
                  z_ff[i+1] <= z_ff[i] + atan_value(5'(i));
               end else begin
                  x_ff[i+1] <= x_ff[i] - ys;
                  y_ff[i+1] <= y_ff[i] + xs;
                  z_ff[i+1] <= z_ff[i] - atan_value(5'(i));
               end
            end
         end
      end
   endgenerate

   // Clamp to the half turn and round half up to a hundredth of a degree.
   logic signed [ZACC_WIDTH-1:0] z_clamped;
   logic        [ZACC_WIDTH-1:0] z_rounded;

   always_comb begin
      if (z_ff[NUM_STAGES] < 0) begin
         z_clamped = '0;
      end else if (z_ff[NUM_STAGES] > ANGLE_180) begin
         z_clamped = ANGLE_180;
      end else begin
         z_clamped = z_ff[NUM_STAGES];
      end
      z_rounded = unsigned'(z_clamped) + ZACC_WIDTH'(1 << (ANGLE_FRAC - 1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= z_rounded[ANGLE_FRAC+ANGLE_WIDTH-1:ANGLE_FRAC];
      end
   end

   assign angle = angle_ff;

endmodule

### rtl/accelerometer_tilt_angles.sv
// Accelerometer tilt angles: magnitude and three axis angles from a sample triple.
// Top level; depends on tilt_pkg, tilt_delay, tilt_sqrt, tilt_div and tilt_cordic.
//
// Usage:
//   req_ channel: one beat carries the x, y and z converter samples.
//   rsp_ channel: one beat per request with the magnitude in 1/256 g and the
//   angle of each axis to the vector in hundredths of a degree; rsp_tuser
//   flags a zero vector, for which all fields read zero.
//   csr_ port: index 0 sets the zero-g code, index 1 the counts per g
//   (0 acts as 1). Write only while no beat is in flight.
// The square-root stages and the longer of the divider and CORDIC tails set the
// depth of the pipeline; at the defaults the divider tail is the longer one.
// Throughput is one beat per cycle while the receiver keeps the pipeline advancing.
// Reset clears the valid bits and loads 2048 and 246 into the registers.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline holds and req_tready falls; bubbles still drain into the output.
module accelerometer_tilt_angles import tilt_pkg::*; #(
   parameter int SAMPLE_BITS      = DEFAULT_SAMPLE_BITS,
   parameter int ITERATION_STAGES = DEFAULT_ITERATION_STAGES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request side
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sample_x, sample_y, sample_z from bit 0 up, zero padded
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // Response side
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // magnitude_g, angle_x, angle_y, angle_z from bit 0 up, zero padded
   output logic [63:0]                            rsp_tdata,
   // zero_vector
   output logic                                   rsp_tuser,
   // Configuration
   input  logic                                   csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0]             csr_index,
   input  logic [CSR_WIDTH-1:0]                   csr_wdata
);

   localparam int SB        = SAMPLE_BITS;
   localparam int SQ_BITS   = 2 * SB;
   localparam int SUM_BITS  = 2 * SB + 2;
   localparam int ROOT_BITS = (SUM_BITS + RADICAND_SHIFT) / 2;
   localparam int NUM_BITS  = ROOT_BITS + 1;
   localparam int NS        = (ITERATION_STAGES < ATAN_ENTRIES) ? ITERATION_STAGES
                                                                : ATAN_ENTRIES;
   localparam int MAG_TAIL  = ROOT_BITS + 3;
   localparam int ANG_TAIL  = NS + 2;
   localparam int TAIL      = (MAG_TAIL > ANG_TAIL) ? MAG_TAIL : ANG_TAIL;
   localparam int LAT       = 3 + ROOT_BITS + TAIL;
   localparam int ANG3      = 3 * ANGLE_WIDTH;

   // Configuration registers
   logic [CSR_WIDTH-1:0] zero_g_ff;
   logic [CSR_WIDTH-1:0] cpg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_g_ff <= ZERO_G_RESET;
         cpg_ff    <= COUNTS_PER_G_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ZERO_G:       zero_g_ff <= csr_wdata;
            CSR_COUNTS_PER_G: cpg_ff    <= csr_wdata;
            default:          ;
         endcase
      end
   end

   logic [SB-1:0]        zero_m;
   logic [CSR_WIDTH-1:0] cpg_eff;

   generate
      if (SB <= CSR_WIDTH) begin : g_zero_narrow
         assign zero_m = zero_g_ff[SB-1:0];
      end else begin : g_zero_wide
         assign zero_m = {{(SB-CSR_WIDTH){1'b0}}, zero_g_ff};
      end
   endgenerate

   assign cpg_eff = (cpg_ff == '0) ? CSR_WIDTH'(1) : cpg_ff;

   // Pipeline advance and valid bits
   logic           adv;
   logic [LAT-1:0] vline_ff;
   logic [LAT-1:0] vline_in;

   assign adv        = ~vline_ff[LAT-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vline_ff[LAT-1];
   assign vline_in   = {vline_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vline_ff <= '0;
      end else if (adv) begin
         vline_ff <= vline_in;
      end
   end

   // Stage 1: offset removal
   logic signed [SB:0] d1_ff [3];
   logic signed [SB:0] d1_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d1_in[a] = signed'({1'b0, req_tdata[a*SB +: SB]}) - signed'({1'b0, zero_m});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= d1_in;
      end
   end

   // Stage 2: squares
   logic signed [SB:0]    d2_ff  [3];
   logic [SQ_BITS-1:0]    sq2_ff [3];
   logic [SQ_BITS-1:0]    sq2_in [3];
   logic signed [2*SB+1:0] prod   [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod[a]   = d1_ff[a] * d1_ff[a];
         sq2_in[a] = prod[a][SQ_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff  <= d1_ff;
         sq2_ff <= sq2_in;
      end
   end

   // Stage 3: sum of squares and the part of it normal to each axis
   logic signed [SB:0]   d3_ff    [3];
   logic [SUM_BITS-1:0]  s3_ff;
   logic [SUM_BITS-1:0]  s3_in;
   logic [SUM_BITS-1:0]  perp3_ff [3];
   logic [SUM_BITS-1:0]  perp3_in [3];
   logic                 zero3_ff;

   always_comb begin
      s3_in = SUM_BITS'(sq2_ff[0]) + SUM_BITS'(sq2_ff[1]) + SUM_BITS'(sq2_ff[2]);
      for (int a = 0; a < 3; a++) begin
         perp3_in[a] = s3_in - SUM_BITS'(sq2_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff    <= d2_ff;
         s3_ff    <= s3_in;
         perp3_ff <= perp3_in;
         zero3_ff <= (s3_in == '0);
      end
   end

   // Square roots of the scaled sums
   logic [ROOT_BITS-1:0] mag_root;
   logic [ROOT_BITS-1:0] perp_root [3];

   tilt_sqrt #(.ROOT_BITS(ROOT_BITS)) u_sqrt_mag (
      .clock    (clock),
      .adv      (adv),
      .radicand ({s3_ff, {RADICAND_SHIFT{1'b0}}}),
      .root     (mag_root)
   );

   // Magnitude tail: rounding offset, division, saturation
   logic [NUM_BITS-1:0]  numer_ff;
   logic [NUM_BITS-1:0]  quot;
   logic [MAG_WIDTH-1:0] mag_ff;
   logic [MAG_WIDTH-1:0] mag_in;
   logic [MAG_WIDTH-1:0] mag_out;

   always_ff @(posedge clock) begin
      if (adv) begin
         numer_ff <= NUM_BITS'(mag_root) + NUM_BITS'(cpg_eff >> 1);
      end
   end

   tilt_div #(.NUM_BITS(NUM_BITS)) u_div (
      .clock (clock),
      .adv   (adv),
      .numer (numer_ff),
      .denom (cpg_eff),
      .quot  (quot)
   );

   assign mag_in = (|quot[NUM_BITS-1:MAG_WIDTH]) ? MAG_MAX : quot[MAG_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
      end
   end

   tilt_delay #(.WIDTH(MAG_WIDTH), .DEPTH(TAIL - MAG_TAIL)) u_mag_pad (
      .clock (clock),
      .adv   (adv),
      .din   (mag_ff),
      .dout  (mag_out)
   );

   // Angle per axis
   logic [ANG3-1:0] angles;
   logic [ANG3-1:0] angles_out;

   generate
      for (genvar a = 0; a < 3; a++) begin : g_axis
         logic signed [SB:0] d_aligned;

         tilt_sqrt #(.ROOT_BITS(ROOT_BITS)) u_sqrt_perp (
            .clock    (clock),
            .adv      (adv),
            .radicand ({perp3_ff[a], {RADICAND_SHIFT{1'b0}}}),
            .root     (perp_root[a])
         );

         tilt_delay #(.WIDTH(SB + 1), .DEPTH(ROOT_BITS)) u_axis_delay (
            .clock (clock),
            .adv   (adv),
            .din   (d3_ff[a]),
            .dout  (d_aligned)
         );

         tilt_cordic #(
            .SAMPLE_BITS (SB),
            .ROOT_BITS   (ROOT_BITS),
            .NUM_STAGES  (NS)
         ) u_cordic (
            .clock (clock),
            .adv   (adv),
            .axis  (d_aligned),
            .perp  (perp_root[a]),
            .angle (angles[a*ANGLE_WIDTH +: ANGLE_WIDTH])
         );
      end
   endgenerate

   tilt_delay #(.WIDTH(ANG3), .DEPTH(TAIL - ANG_TAIL)) u_angle_pad (
      .clock (clock),
      .adv   (adv),
      .din   (angles),
      .dout  (angles_out)
   );

   // Zero-vector flag follows the item to the output
   logic zero_out;

   tilt_delay #(.WIDTH(1), .DEPTH(ROOT_BITS + TAIL)) u_zero_delay (
      .clock (clock),
      .adv   (adv),
      .din   (zero3_ff),
      .dout  (zero_out)
   );

   // Output beat; a zero vector forces every field to zero
   assign rsp_tuser = zero_out;
   assign rsp_tdata = zero_out ? 64'd0
                               : {{(64 - MAG_WIDTH - ANG3){1'b0}}, angles_out, mag_out};

endmodule
